// ----- rtl/core/dbwe_pkg.sv -----
// Package for the banded window expansion core: configuration record, item
// tag, operation and register codes, field widths.
// No dependencies; used by every module of the core except dbwe_ram.
`default_nettype none

package dbwe_pkg;

  // field widths of the word ports
  localparam int unsigned STORE_W = 8;   // coarse start/end columns
  localparam int unsigned ROW_W   = 8;   // coarse row index
  localparam int unsigned FROW_W  = 10;  // fine row index
  localparam int unsigned OUT_W   = 10;  // fine column results
  localparam int unsigned CNT_W   = 9;   // coarse row/column count registers
  localparam int unsigned RAD_W   = 8;   // band radius register

  // APB side
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  // operation codes
  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_EXPAND = 1'b1
  } op_t;

  // register indexes (byte address / 4)
  typedef enum logic [2:0] {
    REG_ROWS   = 3'd0,
    REG_COLS   = 3'd1,
    REG_RPAR   = 3'd2,
    REG_CPAR   = 3'd3,
    REG_RADIUS = 3'd4
  } reg_idx_t;

  // programmed configuration
  typedef struct packed {
    logic [CNT_W-1:0] rows;
    logic [CNT_W-1:0] cols;
    logic             rpar;
    logic             cpar;
    logic [RAD_W-1:0] radius;
  } cfg_t;

  // tag carried alongside a word waiting on the store read
  typedef struct packed {
    logic expand;  // expand word (else write word)
    logic bad;     // row index out of range
  } item_t;

endpackage

`default_nettype wire

// ----- rtl/core/dbwe_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module dbwe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dbwe_cfg.sv -----
// APB register file for the window expansion core: rows, columns, parities
// and band radius. Depends on dbwe_pkg.
`default_nettype none

module dbwe_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [dbwe_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [dbwe_pkg::PDATA_W-1:0]  pwdata,
  output      logic [dbwe_pkg::PDATA_W-1:0]  prdata,
  output      logic                          pready,
  output      dbwe_pkg::cfg_t                cfg
);

  logic               wr_en;
  dbwe_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = dbwe_pkg::reg_idx_t'(paddr[dbwe_pkg::PADDR_W-1:2]);

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rows   <= dbwe_pkg::CNT_W'(1);
      cfg.cols   <= dbwe_pkg::CNT_W'(1);
      cfg.rpar   <= 1'b0;
      cfg.cpar   <= 1'b0;
      cfg.radius <= dbwe_pkg::RAD_W'(1);
    end else if (wr_en) begin
      unique case (idx)
        dbwe_pkg::REG_ROWS:   cfg.rows   <= pwdata[dbwe_pkg::CNT_W-1:0];
        dbwe_pkg::REG_COLS:   cfg.cols   <= pwdata[dbwe_pkg::CNT_W-1:0];
        dbwe_pkg::REG_RPAR:   cfg.rpar   <= pwdata[0];
        dbwe_pkg::REG_CPAR:   cfg.cpar   <= pwdata[0];
        dbwe_pkg::REG_RADIUS: cfg.radius <= pwdata[dbwe_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // read-back
  always_comb begin
    prdata = '0;
    unique case (idx)
      dbwe_pkg::REG_ROWS:   prdata = dbwe_pkg::PDATA_W'(cfg.rows);
      dbwe_pkg::REG_COLS:   prdata = dbwe_pkg::PDATA_W'(cfg.cols);
      dbwe_pkg::REG_RPAR:   prdata = dbwe_pkg::PDATA_W'(cfg.rpar);
      dbwe_pkg::REG_CPAR:   prdata = dbwe_pkg::PDATA_W'(cfg.cpar);
      dbwe_pkg::REG_RADIUS: prdata = dbwe_pkg::PDATA_W'(cfg.radius);
      default:              prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/dbwe_calc.sv -----
// Column widening for one fine row: scales the coarse bounds read from the
// stores, applies the radius and clamps to the fine grid. Depends on dbwe_pkg.
`default_nettype none

module dbwe_calc #(
  parameter int unsigned MAX_COARSE_COLS = 256
) (
  input  wire dbwe_pkg::cfg_t                    cfg,
  input  wire logic [dbwe_pkg::STORE_W-1:0]      start_rd,
  input  wire logic [dbwe_pkg::STORE_W-1:0]      end_rd,
  output      logic [dbwe_pkg::OUT_W-1:0]        start_col,
  output      logic [dbwe_pkg::OUT_W-1:0]        end_col
);

  localparam int unsigned MCW  = $clog2(MAX_COARSE_COLS + 1);
  localparam int unsigned MW   = (MCW > dbwe_pkg::CNT_W) ? MCW : dbwe_pkg::CNT_W;
  localparam int unsigned EN_W = dbwe_pkg::STORE_W + 3;
  localparam int unsigned CW   = (MW + 1 > EN_W) ? MW + 1 : EN_W;

  logic [MW-1:0]                 cols_ext;
  logic [MW-1:0]                 m_eff;
  logic [CW-1:0]                 fine_last;
  logic [dbwe_pkg::STORE_W:0]    st2;
  logic [dbwe_pkg::STORE_W:0]    rad_ext;
  logic [dbwe_pkg::STORE_W:0]    st;
  logic [CW-1:0]                 en;
  logic [CW-1:0]                 en_c;

  // effective column count: zero acts as one, saturate at the maximum
  assign cols_ext = MW'(cfg.cols);
  always_comb begin
    if (cfg.cols == '0) begin
      m_eff = MW'(1);
    end else if (cols_ext > MW'(MAX_COARSE_COLS)) begin
      m_eff = MW'(MAX_COARSE_COLS);
    end else begin
      m_eff = cols_ext;
    end
  end

  assign fine_last = (CW'(m_eff) << 1) + CW'(cfg.cpar) - CW'(1);

  // start: 2*s - R, floored at zero
  assign st2     = {start_rd, 1'b0};
  assign rad_ext = (dbwe_pkg::STORE_W + 1)'(cfg.radius);
  assign st      = (st2 > rad_ext) ? st2 - rad_ext : '0;

  // end: 2*e + 1 + R + cpar, capped at the last fine column
  assign en   = (CW'(end_rd) << 1) + CW'(1) + CW'(cfg.radius) + CW'(cfg.cpar);
  assign en_c = (en > fine_last) ? fine_last : en;

  assign start_col = dbwe_pkg::OUT_W'(st);
  assign end_col   = en_c[dbwe_pkg::OUT_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/core/dtw_band_window_expand_core.sv -----
// Banded DTW window expansion core: coarse row bounds kept in two RAMs.
// Store read data and item tag register on acceptance, then the output register.
// Throughput: one word per cycle, set by the store read register; a stalled output
// holds the read stage and the input side behind it. Reset: control and parities
// cleared, rows/cols/radius to 1; store contents undefined until written.
// Depends on dbwe_pkg, dbwe_cfg, dbwe_ram, dbwe_calc.
`default_nettype none

module dtw_band_window_expand_core #(
  parameter int unsigned MAX_COARSE_ROWS = 256,
  parameter int unsigned MAX_COARSE_COLS = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // APB configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [dbwe_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [dbwe_pkg::PDATA_W-1:0]  pwdata,
  output      logic [dbwe_pkg::PDATA_W-1:0]  prdata,
  output      logic                          pready,
  // input words
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic                          op,
  input  wire logic [dbwe_pkg::ROW_W-1:0]    coarse_row,
  input  wire logic [dbwe_pkg::STORE_W-1:0]  start_in,
  input  wire logic [dbwe_pkg::STORE_W-1:0]  end_in,
  input  wire logic [dbwe_pkg::FROW_W-1:0]   fine_row,
  // result words
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic [dbwe_pkg::OUT_W-1:0]    start_out,
  output      logic [dbwe_pkg::OUT_W-1:0]    end_out,
  output      logic                          status
);

  localparam int unsigned IW  = $clog2(MAX_COARSE_ROWS);
  localparam int unsigned NRW = $clog2(MAX_COARSE_ROWS + 1);
  localparam int unsigned EW  = (NRW > dbwe_pkg::CNT_W) ? NRW : dbwe_pkg::CNT_W;
  localparam int unsigned AW  = EW + 2;

  dbwe_pkg::cfg_t  cfg;
  dbwe_pkg::item_t item;
  dbwe_pkg::item_t item_next;

  logic            item_valid;
  logic            out_free;
  logic            accept;
  logic            ram_we;
  logic [IW-1:0]   waddr;
  logic [IW-1:0]   lo_addr;
  logic [IW-1:0]   hi_addr;

  logic [EW-1:0]   rows_ext;
  logic [EW-1:0]   n_eff;
  logic [AW-1:0]   top_row;
  logic [AW-1:0]   fine_lim;
  logic [AW-1:0]   fr;
  logic [AW-1:0]   rad;
  logic [AW-1:0]   lo_raw;
  logic [AW-1:0]   hi_raw;
  logic [AW-1:0]   lo_c;
  logic [AW-1:0]   hi_c;
  logic            bad_wr;
  logic            bad_ex;

  logic [dbwe_pkg::STORE_W-1:0] start_rd;
  logic [dbwe_pkg::STORE_W-1:0] end_rd;
  logic [dbwe_pkg::OUT_W-1:0]   start_col;
  logic [dbwe_pkg::OUT_W-1:0]   end_col;

  // configuration registers
  dbwe_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // handshake: read stage advances when the output register is free
  assign out_free = !out_valid || !out_stall;
  assign in_stall = item_valid && !out_free;
  assign accept   = in_valid && !in_stall;

  // effective coarse row count
  assign rows_ext = EW'(cfg.rows);
  always_comb begin
    if (cfg.rows == '0) begin
      n_eff = EW'(1);
    end else if (rows_ext > EW'(MAX_COARSE_ROWS)) begin
      n_eff = EW'(MAX_COARSE_ROWS);
    end else begin
      n_eff = rows_ext;
    end
  end

  // fine-row window clamped to the coarse grid
  assign top_row  = (AW'(n_eff) - AW'(1)) << 1;
  assign fine_lim = (AW'(n_eff) << 1) + AW'(cfg.rpar);
  assign fr       = AW'(fine_row);
  assign rad      = AW'(cfg.radius);
  assign lo_raw   = (fr > rad) ? fr - rad : '0;
  assign hi_raw   = fr + rad;
  assign lo_c     = (lo_raw > top_row) ? top_row : lo_raw;
  assign hi_c     = (hi_raw > top_row) ? top_row : hi_raw;
  assign lo_addr  = IW'(lo_c >> 1);
  assign hi_addr  = IW'(hi_c >> 1);

  // range checks
  assign bad_wr = AW'(coarse_row) >= AW'(n_eff);
  assign bad_ex = fr >= fine_lim;

  // an in-range write word stores at its accepting edge; later reads see it
  assign ram_we = accept && (dbwe_pkg::op_t'(op) == dbwe_pkg::OP_WRITE) && !bad_wr;
  assign waddr  = IW'(coarse_row);

  assign item_next.expand = (dbwe_pkg::op_t'(op) == dbwe_pkg::OP_EXPAND);
  assign item_next.bad    = item_next.expand ? bad_ex : bad_wr;

  dbwe_ram #(
    .WIDTH (dbwe_pkg::STORE_W),
    .DEPTH (MAX_COARSE_ROWS)
  ) u_start_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (start_in),
    .re    (accept),
    .raddr (lo_addr),
    .rdata (start_rd)
  );

  dbwe_ram #(
    .WIDTH (dbwe_pkg::STORE_W),
    .DEPTH (MAX_COARSE_ROWS)
  ) u_end_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (end_in),
    .re    (accept),
    .raddr (hi_addr),
    .rdata (end_rd)
  );

  dbwe_calc #(
    .MAX_COARSE_COLS (MAX_COARSE_COLS)
  ) u_calc (
    .cfg       (cfg),
    .start_rd  (start_rd),
    .end_rd    (end_rd),
    .start_col (start_col),
    .end_col   (end_col)
  );

  // read stage tag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (out_free) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && item_valid) begin
      status <= item.bad;
      if (item.expand && !item.bad) begin
        start_out <= start_col;
        end_out   <= end_col;
      end else begin
        start_out <= '0;
        end_out   <= '0;
      end
    end
  end

  // an out-of-range write never reaches the stores
  a_no_bad_write: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !bad_wr)
    else $error("store written with coarse row out of range");

  // an accepted word occupies the read stage next cycle
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> item_valid)
    else $error("accepted word lost before read stage");

  // a held read stage keeps its word while the output is blocked
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !out_free) |=> (item_valid && $stable(item)))
    else $error("read stage changed while output blocked");

  // input is only held back by a busy read stage
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (item_valid && out_valid))
    else $error("input stalled with a free pipeline");

endmodule

`default_nettype wire

// ----- tb/sv/dtw_band_window_expand_core_test.sv -----
// Self-checking bench for dtw_band_window_expand_core: a scoreboard class
// that predicts each fine-row window, plus tasks driving the APB port and word ports.
// Depends on dbwe_pkg and the core RTL only.

module dtw_band_window_expand_core_test;

  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned SPARE_REG_FIRST = 5;
  localparam int unsigned SPARE_REG_LAST  = 7;
  localparam int unsigned PHASES          = 11;

  // Expected windows for accepted words, in acceptance order
  class window_scoreboard;
    localparam int MAX_ROWS = 256;
    localparam int MAX_COLS = 256;

    typedef struct packed {
      logic [dbwe_pkg::OUT_W-1:0] first_col;
      logic [dbwe_pkg::OUT_W-1:0] last_col;
      logic                       bad;
    } window_t;

    // shadow of the programmed setting
    logic [dbwe_pkg::CNT_W-1:0] rows;
    logic [dbwe_pkg::CNT_W-1:0] cols;
    logic                       rpar;
    logic                       cpar;
    logic [dbwe_pkg::RAD_W-1:0] radius;

    // shadow of the coarse window
    logic [dbwe_pkg::STORE_W-1:0] row_first [MAX_ROWS];
    logic [dbwe_pkg::STORE_W-1:0] row_last [MAX_ROWS];

    window_t pending [$];
    int      errors;
    int      checked;

    function new();
      rows    = 1;
      cols    = 1;
      rpar    = 1'b0;
      cpar    = 1'b0;
      radius  = 1;
      errors  = 0;
      checked = 0;
    endfunction

    function void write_reg(int unsigned idx, logic [31:0] value);
      case (idx)
        dbwe_pkg::REG_ROWS:   rows = value[dbwe_pkg::CNT_W-1:0];
        dbwe_pkg::REG_COLS:   cols = value[dbwe_pkg::CNT_W-1:0];
        dbwe_pkg::REG_RPAR:   rpar = value[0];
        dbwe_pkg::REG_CPAR:   cpar = value[0];
        dbwe_pkg::REG_RADIUS: radius = value[dbwe_pkg::RAD_W-1:0];
        default: ;
      endcase
    endfunction

    // zero acts as one, oversized counts saturate
    function int rows_eff();
      if (rows == 0) return 1;
      if (int'(rows) > MAX_ROWS) return MAX_ROWS;
      return int'(rows);
    endfunction

    function int cols_eff();
      if (cols == 0) return 1;
      if (int'(cols) > MAX_COLS) return MAX_COLS;
      return int'(cols);
    endfunction

    function int fine_rows();
      return 2 * rows_eff() + int'(rpar);
    endfunction

    // coarse row under fine row frow+shift, clamped to the coarse grid
    function int band_row(int frow, int shift);
      int top;
      int v;
      top = 2 * (rows_eff() - 1);
      v = frow + shift;
      if (v < 0) v = 0;
      if (v > top) v = top;
      return v / 2;
    endfunction

    function void note_word(dbwe_pkg::op_t kind, logic [7:0] crow, logic [7:0] s,
                            logic [7:0] e, logic [9:0] frow);
      window_t w;
      int lo;
      int hi;
      int first;
      int last;
      int last_fine;
      w = '0;
      if (kind == dbwe_pkg::OP_WRITE) begin
        if (int'(crow) >= rows_eff()) begin
          w.bad = 1'b1;
        end else begin
          row_first[crow] = s;
          row_last[crow] = e;
        end
      end else if (int'(frow) >= fine_rows()) begin
        w.bad = 1'b1;
      end else begin
        lo = band_row(int'(frow), -int'(radius));
        hi = band_row(int'(frow), int'(radius));
        first = 2 * int'(row_first[lo]) - int'(radius);
        last = 2 * int'(row_last[hi]) + 1 + int'(radius) + int'(cpar);
        last_fine = 2 * cols_eff() + int'(cpar) - 1;
        if (first < 0) first = 0;
        if (last > last_fine) last = last_fine;
        w.first_col = first[dbwe_pkg::OUT_W-1:0];
        w.last_col = last[dbwe_pkg::OUT_W-1:0];
      end
      pending.push_back(w);
    endfunction

    // one line per mismatch
    task report(string note);
      errors++;
      $display("MISMATCH: %s", note);
    endtask

    task check_result(logic [9:0] first, logic [9:0] last, logic bad);
      window_t want;
      checked++;
      if (pending.size() == 0) begin
        report($sformatf("result word %0d arrived with nothing pending", checked));
        return;
      end
      want = pending.pop_front();
      if (first !== want.first_col)
        report($sformatf("word %0d start_out %0d, expected %0d", checked, first,
                         want.first_col));
      if (last !== want.last_col)
        report($sformatf("word %0d end_out %0d, expected %0d", checked, last,
                         want.last_col));
      if (bad !== want.bad)
        report($sformatf("word %0d status %0b, expected %0b", checked, bad, want.bad));
    endtask
  endclass

  logic                         clk;
  logic                         rst;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [dbwe_pkg::PADDR_W-1:0] paddr;
  logic [dbwe_pkg::PDATA_W-1:0] pwdata;
  logic [dbwe_pkg::PDATA_W-1:0] prdata;
  logic                         pready;
  logic                         in_valid;
  logic                         in_stall;
  dbwe_pkg::op_t                word_op;
  logic [dbwe_pkg::ROW_W-1:0]   coarse_row;
  logic [dbwe_pkg::STORE_W-1:0] start_in;
  logic [dbwe_pkg::STORE_W-1:0] end_in;
  logic [dbwe_pkg::FROW_W-1:0]  fine_row;
  logic                         out_valid;
  logic                         out_stall;
  logic [dbwe_pkg::OUT_W-1:0]   start_out;
  logic [dbwe_pkg::OUT_W-1:0]   end_out;
  logic                         status;

  window_scoreboard sb;
  bit               row_written [256];
  bit               idle_on = 1'b1;
  bit               stall_on = 1'b1;
  bit               hold_req = 1'b0;
  int unsigned      quiet_cycles = 0;
  int unsigned      words_sent = 0;
  int unsigned      expands_sent = 0;
  int unsigned      settings_used = 0;

  dtw_band_window_expand_core uut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (word_op),
    .coarse_row (coarse_row),
    .start_in   (start_in),
    .end_in     (end_in),
    .fine_row   (fine_row),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .start_out  (start_out),
    .end_out    (end_out),
    .status     (status)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // result side: check every accepted word
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(start_out, end_out, status);
  end

  // watchdog: cycles without any handshake on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("Watchdog: no handshake for %0d cycles, %0d words still expected",
             WATCHDOG_LIMIT, sb.pending.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
        hold_req = 1'b0;
      end else if (stall_on && $urandom_range(0, 7) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // one APB write: setup then access, register taken when pready is high
  task automatic apb_write(int unsigned idx, logic [31:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = dbwe_pkg::PADDR_W'(idx * 4);
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.write_reg(idx, value);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // random junk above the register width now and then
  function automatic logic [31:0] with_noise(int unsigned v, int unsigned w);
    logic [31:0] noise;
    noise = ($urandom_range(0, 3) == 0) ? ($urandom << w) : 32'd0;
    return noise | v;
  endfunction

  task automatic wait_drain();
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  // reprogram the window setting once the block has gone quiet
  task automatic set_window(int unsigned rows_v, int unsigned cols_v, int unsigned rpar_v,
                            int unsigned cpar_v, int unsigned rad_v);
    wait_drain();
    repeat (4) @(negedge clk);
    apb_write(dbwe_pkg::REG_ROWS, with_noise(rows_v, dbwe_pkg::CNT_W));
    apb_write(dbwe_pkg::REG_COLS, with_noise(cols_v, dbwe_pkg::CNT_W));
    apb_write(dbwe_pkg::REG_RPAR, with_noise(rpar_v, 1));
    apb_write(dbwe_pkg::REG_CPAR, with_noise(cpar_v, 1));
    apb_write(dbwe_pkg::REG_RADIUS, with_noise(rad_v, dbwe_pkg::RAD_W));
    // unmapped addresses must not alias onto a real register
    if (settings_used == 0 || $urandom_range(0, 2) == 0)
      apb_write($urandom_range(SPARE_REG_FIRST, SPARE_REG_LAST), $urandom);
    settings_used++;
  endtask

  // offer one word and hold it until taken
  task automatic send_word(dbwe_pkg::op_t kind, logic [7:0] crow, logic [7:0] s,
                           logic [7:0] e, logic [9:0] frow);
    if (idle_on && $urandom_range(0, 6) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    if (kind == dbwe_pkg::OP_WRITE && int'(crow) < sb.rows_eff()) row_written[crow] = 1'b1;
    word_op = kind;
    coarse_row = crow;
    start_in = s;
    end_in = e;
    fine_row = frow;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_word(kind, crow, s, e, frow);
    words_sent++;
    if (kind == dbwe_pkg::OP_EXPAND) expands_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_row(int crow);
    send_word(dbwe_pkg::OP_WRITE, crow[7:0], 8'($urandom), 8'($urandom), 10'($urandom));
  endtask

  // expand a fine row; coarse rows it would read unwritten get written instead
  task automatic expand_row(int frow);
    int lo;
    int hi;
    if (frow < sb.fine_rows()) begin
      lo = sb.band_row(frow, -int'(sb.radius));
      hi = sb.band_row(frow, int'(sb.radius));
      if (!row_written[lo]) begin
        write_row(lo);
        return;
      end
      if (!row_written[hi]) begin
        write_row(hi);
        return;
      end
    end
    send_word(dbwe_pkg::OP_EXPAND, 8'($urandom), 8'($urandom), 8'($urandom), frow[9:0]);
  endtask

  // mostly in-grid traffic, with some out-of-range rows mixed in
  task automatic run_phase(int unsigned words);
    int n;
    int unsigned pick;
    n = sb.rows_eff();
    for (int r = 0; r < n && r < 8; r++) write_row(r);
    repeat (words) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) write_row($urandom_range(0, n - 1));
      else if (pick < 38) write_row($urandom_range(0, 255));
      else if (pick < 90) expand_row($urandom_range(0, sb.fine_rows() - 1));
      else expand_row($urandom_range(0, 1023));
    end
  endtask

  initial begin
    int unsigned r_v;
    int unsigned c_v;
    int unsigned rad_v;
    sb = new();
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    word_op = dbwe_pkg::OP_WRITE;
    coarse_row = '0;
    start_in = '0;
    end_in = '0;
    fine_row = '0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // reset setting: one coarse row and column, radius one
    send_word(dbwe_pkg::OP_EXPAND, 8'd0, 8'd0, 8'd0, 10'h3FF);
    send_word(dbwe_pkg::OP_WRITE, 8'd0, 8'hFF, 8'hFF, 10'd0);
    send_word(dbwe_pkg::OP_EXPAND, 8'hFF, 8'hFF, 8'hFF, 10'd0);   // reads the row just written
    send_word(dbwe_pkg::OP_WRITE, 8'hFF, 8'h00, 8'h00, 10'h3FF);  // row beyond the grid
    send_word(dbwe_pkg::OP_EXPAND, 8'd0, 8'd0, 8'd0, 10'd1);
    send_word(dbwe_pkg::OP_EXPAND, 8'd0, 8'd0, 8'd0, 10'd2);      // first fine row past the grid

    // zero counts act as one; parity rows and columns on; no widening
    set_window(0, 0, 1, 1, 0);
    send_word(dbwe_pkg::OP_EXPAND, 8'd0, 8'd0, 8'd0, 10'd2);      // the extra parity row
    send_word(dbwe_pkg::OP_WRITE, 8'd0, 8'd0, 8'd0, 10'd0);
    send_word(dbwe_pkg::OP_EXPAND, 8'd0, 8'd0, 8'd0, 10'd0);
    send_word(dbwe_pkg::OP_EXPAND, 8'd0, 8'd0, 8'd0, 10'd3);

    // oversized counts saturate; widest radius
    set_window(511, 300, 1, 1, 255);
    send_word(dbwe_pkg::OP_WRITE, 8'd255, 8'hFF, 8'hFF, 10'd0);
    send_word(dbwe_pkg::OP_WRITE, 8'd128, 8'h01, 8'h80, 10'd0);
    send_word(dbwe_pkg::OP_WRITE, 8'd127, 8'hFF, 8'h00, 10'd0);
    expand_row(512);
    expand_row(0);
    expand_row(513);
    expand_row(255);
    expand_row(1023);

    // random settings and traffic
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      if (phase == 1) begin
        set_window(256, 256, 0, 1, 255);
      end else begin
        case ($urandom_range(0, 7))
          0: r_v = 0;
          1: r_v = $urandom_range(257, 511);
          2: r_v = $urandom_range(17, 256);
          default: r_v = $urandom_range(1, 16);
        endcase
        c_v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 24);
        case ($urandom_range(0, 5))
          0: rad_v = 0;
          1: rad_v = 255;
          2: rad_v = $urandom_range(0, 255);
          default: rad_v = $urandom_range(1, 6);
        endcase
        set_window(r_v, c_v, $urandom_range(0, 1), $urandom_range(0, 1), rad_v);
      end
      if (phase == PHASES - 1) begin
        idle_on = 1'b0;
        stall_on = 1'b0;
      end
      // long output hold-off while words keep coming, so the input backs up
      if (phase == 3) hold_req = 1'b1;
      if (phase == 6) begin
        run_phase(35);
        wait_drain();
        run_phase(35);
      end else begin
        run_phase(70);
      end
    end

    wait_drain();
    repeat (8) @(negedge clk);
    $display("Covered %0d words (%0d expands) over %0d window settings, %0d results checked.",
             words_sent, expands_sent, settings_used, sb.checked);
    $display("Included saturated and zero counts, parity rows, an output hold-off and a drain.");
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
